// ===== hdl/bsc_pkg.sv =====
// Shared types and constants for the barometric sensor compensation pipeline.
package bsc_pkg;

  localparam int unsigned RawW     = 20;
  localparam int unsigned TempW    = 19;
  localparam int unsigned PressW   = 32;
  localparam int unsigned CfgW     = 48;
  localparam int unsigned CfgIdxW  = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegTempCoef  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPressLow  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPressMid  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegPressHigh = 2'd3;

  // Stage counts: front arithmetic, divider load plus one stage per quotient bit, back end
  localparam int unsigned FrontStages = 8;
  localparam int unsigned DivBits     = PressW;
  localparam int unsigned BackStages  = 3;
  localparam int unsigned NumStages   = FrontStages + DivBits + 1 + BackStages;

  typedef struct packed {
    logic [RawW-1:0] raw_temperature;
    logic [RawW-1:0] raw_pressure;
  } bsc_in_t;

  typedef struct packed {
    logic signed [TempW-1:0] temperature_centi;
    logic [PressW-1:0]       pressure_pa;
    logic                    zero_divisor;
  } bsc_out_t;

endpackage

// ===== hdl/barometric_sensor_compensation.sv =====
// Pipelined integer temperature and pressure compensation with a staged divider.
//
//  channel  | direction | handshake                 | beat
//  ---------+-----------+---------------------------+-------------------------------
//  in       | sink      | in_valid_i / in_stall_o   | raw_temperature, raw_pressure
//  out      | source    | out_valid_o / out_stall_i | temperature_centi, pressure_pa,
//           |           |                           | zero_divisor
//  cfg      | sink      | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// One beat enters per cycle unless the output stalls; each passes through
// eight front stages, one divider load stage, 32 restoring divider stages (one quotient
// bit each) and three correction stages, the last being the output register.
// The pipeline advances as one when the output register is empty or taken, so a
// stalled output holds every stage. Reset clears valid bits and calibration registers.
module barometric_sensor_compensation
  import bsc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bsc_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bsc_out_t            out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i
);

  // Calibration registers
  logic [CfgW-1:0] tc_q, plo_q, pmid_q, phi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q   <= '0;
      plo_q  <= '0;
      pmid_q <= '0;
      phi_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegTempCoef:  tc_q   <= cfg_data_i;
        RegPressLow:  plo_q  <= cfg_data_i;
        RegPressMid:  pmid_q <= cfg_data_i;
        RegPressHigh: phi_q  <= cfg_data_i;
        default:      tc_q   <= tc_q;
      endcase
    end
  end

  // Coefficient words
  logic [15:0]        t1u, p1u;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1u = tc_q[15:0];
  assign t2  = $signed(tc_q[31:16]);
  assign t3  = $signed(tc_q[47:32]);
  assign p1u = plo_q[15:0];
  assign p2  = $signed(plo_q[31:16]);
  assign p3  = $signed(plo_q[47:32]);
  assign p4  = $signed(pmid_q[15:0]);
  assign p5  = $signed(pmid_q[31:16]);
  assign p6  = $signed(pmid_q[47:32]);
  assign p7  = $signed(phi_q[15:0]);
  assign p8  = $signed(phi_q[31:16]);
  assign p9  = $signed(phi_q[47:32]);

  // Global advance: move everything unless the output beat is held
  logic                 adv;
  logic [NumStages-1:0] v_q;
  assign adv        = !(v_q[NumStages-1] && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NumStages-2:0], in_valid_i};
    end
  end

  // Stage 1: temperature products
  logic signed [18:0] s1_x;
  logic signed [17:0] s1_d;
  logic signed [34:0] s1_xt2_q;
  logic signed [35:0] s1_dd_q;
  logic [RawW-1:0]    s1_ap_q;
  assign s1_x = $signed({2'b00, in_data_i.raw_temperature[19:3]})
              - $signed({2'b00, t1u, 1'b0});
  assign s1_d = $signed({2'b00, in_data_i.raw_temperature[19:4]})
              - $signed({2'b00, t1u});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_xt2_q <= 35'(s1_x) * 35'(t2);
      s1_dd_q  <= 36'(s1_d) * 36'(s1_d);
      s1_ap_q  <= in_data_i.raw_pressure;
    end
  end

  // Stage 2: scale and apply T3
  logic signed [23:0] s2_at_q;
  logic signed [39:0] s2_bt3_q;
  logic [RawW-1:0]    s2_ap_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_at_q  <= 24'(s1_xt2_q >>> 11);
      s2_bt3_q <= 40'(24'(s1_dd_q >>> 12)) * 40'(t3);
      s2_ap_q  <= s1_ap_q;
    end
  end

  // Stage 3: fine temperature
  logic signed [24:0] s3_fine_q;
  logic [RawW-1:0]    s3_ap_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_fine_q <= 25'(s2_at_q) + 25'(s2_bt3_q >>> 14);
      s3_ap_q   <= s2_ap_q;
    end
  end

  // Stage 4: temperature result and pressure offset
  logic signed [29:0]      s4_t5;
  logic signed [TempW-1:0] s4_temp_q;
  logic signed [25:0]      s4_a1_q;
  logic [RawW-1:0]         s4_ap_q;
  assign s4_t5 = 30'(s3_fine_q) * 30'sd5 + 30'sd128;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_temp_q <= s4_t5[26:8];
      s4_a1_q   <= 26'(s3_fine_q >>> 1) - 26'sd64000;
      s4_ap_q   <= s3_ap_q;
    end
  end

  // Stage 5: square and linear terms
  logic signed [23:0]      s5_h;
  logic signed [47:0]      s5_sq_q;
  logic signed [43:0]      s5_a1p5_q, s5_p2a1_q;
  logic signed [TempW-1:0] s5_temp_q;
  logic [RawW-1:0]         s5_ap_q;
  assign s5_h = 24'(s4_a1_q >>> 2);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_sq_q   <= 48'(s5_h) * 48'(s5_h);
      s5_a1p5_q <= 44'(s4_a1_q) * 44'(p5);
      s5_p2a1_q <= 44'(s4_a1_q) * 44'(p2);
      s5_temp_q <= s4_temp_q;
      s5_ap_q   <= s4_ap_q;
    end
  end

  // Stage 6: quadratic terms
  logic signed [51:0]      s6_b1_q;
  logic signed [49:0]      s6_p3s_q;
  logic signed [43:0]      s6_a1p5_q, s6_p2a1_q;
  logic signed [TempW-1:0] s6_temp_q;
  logic [RawW-1:0]         s6_ap_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_b1_q   <= 52'(s5_sq_q >>> 11) * 52'(p6);
      s6_p3s_q  <= 50'(p3) * 50'(s5_sq_q >>> 13);
      s6_a1p5_q <= s5_a1p5_q;
      s6_p2a1_q <= s5_p2a1_q;
      s6_temp_q <= s5_temp_q;
      s6_ap_q   <= s5_ap_q;
    end
  end

  // Stage 7: combine into offset and scale terms
  logic signed [53:0]      s7_bsum;
  logic signed [47:0]      s7_asum;
  logic signed [53:0]      s7_b3_q;
  logic signed [29:0]      s7_a2_q;
  logic signed [TempW-1:0] s7_temp_q;
  logic [RawW-1:0]         s7_ap_q;
  assign s7_bsum = 54'(s6_b1_q) + (54'(s6_a1p5_q) <<< 1);
  assign s7_asum = 48'(s6_p3s_q >>> 3) + 48'(s6_p2a1_q >>> 1);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_b3_q   <= (s7_bsum >>> 2) + (54'(p4) <<< 16);
      s7_a2_q   <= 30'(s7_asum >>> 18);
      s7_temp_q <= s6_temp_q;
      s7_ap_q   <= s6_ap_q;
    end
  end

  // Stage 8: divisor and dividend base
  logic signed [47:0]      s8_prod;
  logic signed [47:0]      s8_a3;
  logic signed [39:0]      s8_num;
  logic [PressW-1:0]       s8_div_q, s8_num_q;
  logic                    s8_zero_q;
  logic signed [TempW-1:0] s8_temp_q;
  assign s8_prod = (48'(s7_a2_q) + 48'sd32768) * $signed({32'd0, p1u});
  assign s8_a3   = s8_prod >>> 15;
  assign s8_num  = 40'sd1048576 - $signed({20'd0, s7_ap_q}) - 40'(s7_b3_q >>> 12);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s8_div_q  <= s8_a3[31:0];
      s8_zero_q <= (s8_a3[31:0] == '0);
      s8_num_q  <= s8_num[31:0];
      s8_temp_q <= s7_temp_q;
    end
  end

  // Divider pipeline: entry 0 is loaded, entry k holds k quotient bits
  logic [PressW-1:0]       dv_rem_q  [0:DivBits];
  logic [PressW-1:0]       dv_dq_q   [0:DivBits];
  logic [PressW-1:0]       dv_div_q  [0:DivBits];
  logic                    dv_hi_q   [0:DivBits];
  logic                    dv_zero_q [0:DivBits];
  logic signed [TempW-1:0] dv_temp_q [0:DivBits];
  logic [PressW:0]         dv_r33    [1:DivBits];
  logic                    dv_ge     [1:DivBits];
  logic [PressW-1:0]       s9_pm;

  assign s9_pm = 32'(s8_num_q * 32'd3125);

  // Compare and subtract per quotient bit
  always_comb begin
    for (int k = 1; k <= DivBits; k++) begin
      dv_r33[k] = {dv_rem_q[k-1], dv_dq_q[k-1][PressW-1]};
      dv_ge[k]  = dv_r33[k] >= {1'b0, dv_div_q[k-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_rem_q[0]  <= '0;
      dv_dq_q[0]   <= s9_pm[PressW-1] ? s9_pm : {s9_pm[PressW-2:0], 1'b0};
      dv_hi_q[0]   <= s9_pm[PressW-1];
      dv_div_q[0]  <= s8_div_q;
      dv_zero_q[0] <= s8_zero_q;
      dv_temp_q[0] <= s8_temp_q;
      for (int k = 1; k <= DivBits; k++) begin
        dv_rem_q[k]  <= dv_ge[k] ? 32'(dv_r33[k] - {1'b0, dv_div_q[k-1]})
                                 : dv_r33[k][PressW-1:0];
        dv_dq_q[k]   <= {dv_dq_q[k-1][PressW-2:0], dv_ge[k]};
        dv_hi_q[k]   <= dv_hi_q[k-1];
        dv_div_q[k]  <= dv_div_q[k-1];
        dv_zero_q[k] <= dv_zero_q[k-1];
        dv_temp_q[k] <= dv_temp_q[k-1];
      end
    end
  end

  // Back 1: rescale quotient, start correction products
  logic [PressW-1:0]       b1_p;
  logic [PressW-1:0]       b1_p_q, b1_qq_q;
  logic signed [47:0]      b1_pb_q;
  logic                    b1_zero_q;
  logic signed [TempW-1:0] b1_temp_q;
  assign b1_p = dv_zero_q[DivBits] ? '0
              : (dv_hi_q[DivBits] ? {dv_dq_q[DivBits][PressW-2:0], 1'b0}
                                  : dv_dq_q[DivBits]);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_p_q    <= b1_p;
      b1_qq_q   <= 32'(b1_p[31:3] * b1_p[31:3]);
      b1_pb_q   <= $signed({18'd0, b1_p[31:2]}) * 48'(p8);
      b1_zero_q <= dv_zero_q[DivBits];
      b1_temp_q <= dv_temp_q[DivBits];
    end
  end

  // Back 2: P9 term and scaling
  logic signed [39:0]      b2_qa;
  logic signed [27:0]      b2_pa_q;
  logic signed [35:0]      b2_pbs_q;
  logic [PressW-1:0]       b2_p_q;
  logic                    b2_zero_q;
  logic signed [TempW-1:0] b2_temp_q;
  assign b2_qa = $signed({21'd0, b1_qq_q[31:13]}) * 40'(p9);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      b2_pa_q   <= 28'(b2_qa >>> 12);
      b2_pbs_q  <= 36'(b1_pb_q >>> 13);
      b2_p_q    <= b1_p_q;
      b2_zero_q <= b1_zero_q;
      b2_temp_q <= b1_temp_q;
    end
  end

  // Back 3: final adjust into the output register
  logic signed [36:0] b3_adj;
  assign b3_adj = (37'(b2_pa_q) + 37'(b2_pbs_q) + 37'(p7)) >>> 4;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_o.temperature_centi <= b2_temp_q;
      out_data_o.pressure_pa       <= b2_zero_q ? '0 : b2_p_q + b3_adj[31:0];
      out_data_o.zero_divisor      <= b2_zero_q;
    end
  end

  assign out_valid_o = v_q[NumStages-1];

  // A zero divisor always forces the pressure to zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_divisor |-> out_data_o.pressure_pa == '0)
    else $error("pressure not forced to zero on zero divisor");

  // The divider remainder stays below a nonzero divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NumStages-1-BackStages] && !dv_zero_q[DivBits]
      |-> dv_rem_q[DivBits] < dv_div_q[DivBits])
    else $error("divider remainder out of range");

  // Input is held off only while a result waits at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // A held output beat keeps the whole pipeline occupancy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(v_q))
    else $error("pipeline moved during output stall");

endmodule
